[rtl/qslerp_pkg.sv]
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared widths, CORDIC arctangent table, sideband types and helpers for the
// quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qslerp_pkg;

  // CORDIC datapath width (Q.30 angles and trig values plus headroom)
  localparam int CW            = 34;
  localparam int ATAN_LEN      = 24;
  localparam int TRIG_ITER_DEF = 16;

  localparam logic signed [CW-1:0] ATAN_TAB [ATAN_LEN] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;

  localparam logic [14:0] THR_RESET = 15'd16383;
  localparam logic [19:0] ONE_Q14   = 20'd16384;
  localparam logic [15:0] ONE_Q15   = 16'h8000;

  // square root: radicand < 2^61, root < 2^31
  localparam int SQ_W   = 61;
  localparam int ROOT_W = 31;
  // divider: dividend |sin| * 2^30 < 2^62, quotient < 2^39
  localparam int DIVR_W = 62;
  localparam int QB     = 39;
  localparam logic [ROOT_W-1:0] S0_MIN = 31'h0080_0000;

  typedef struct packed {
    logic [3:0][16:0] q0;   // start, sign-corrected, Q2.14 with one guard bit
    logic [3:0][15:0] q1;   // end
    logic [15:0]      t;    // clamped fraction
    logic [13:0]      d;    // |dot| rounded to Q0.14
    logic             lin;  // take the linear blend
  } base_t;

  typedef struct packed {
    base_t             b;
    logic [ROOT_W-1:0] s0;
  } mid_t;

  typedef struct packed {
    base_t                b;
    logic signed [CW-1:0] c;
    logic                 neg;
  } div_sb_t;

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    logic [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -64'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/quaternion_slerp.sv]
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point spherical linear interpolation between two quaternions.
// ----------------------------------------------------------------------------
// Input beat: start and end quaternions (Q2.14) and fraction t (Q1.15).
// Output beat: one interpolated quaternion (Q2.14, saturated) plus a flag
// telling whether the near-parallel linear blend was used.
// Both channels are valid/stall; cfg_* writes linear_threshold and is always
// ready (write it only while the pipeline is empty).
// Throughput: one beat per cycle while not stalled. Most of the pipeline is the
// digit-serial square root (31 stages), two CORDIC chains of TRIG_ITERATIONS
// stages (at most the table length each) and the divider (39 stages).
// A stalled output beat freezes the whole pipeline; in_stall rises in the
// same cycle so nothing is dropped or duplicated. Bubbles travel with their
// valid bits.
// Reset clears all valid bits and loads linear_threshold with 16383.
// ----------------------------------------------------------------------------
module quaternion_slerp #(
  parameter int TRIG_ITERATIONS = qslerp_pkg::TRIG_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_start_z,
  input  logic signed [15:0] in_start_w,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic signed [15:0] in_end_z,
  input  logic signed [15:0] in_end_w,
  input  logic [15:0]        in_fraction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w,
  output logic               out_used_linear,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_linear_threshold
);
  import qslerp_pkg::*;

  localparam int ITER = (TRIG_ITERATIONS < ATAN_LEN) ? TRIG_ITERATIONS : ATAN_LEN;

  logic        en;
  logic        out_valid_r;
  logic [14:0] thr_r;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_linear_threshold;
    end
  end

  // ---------------- stage 1: products of the dot ----------------
  logic signed [15:0] a_q0 [4];
  logic signed [15:0] a_q1 [4];
  logic [15:0]        t_in;

  assign a_q0[0] = in_start_x;
  assign a_q0[1] = in_start_y;
  assign a_q0[2] = in_start_z;
  assign a_q0[3] = in_start_w;
  assign a_q1[0] = in_end_x;
  assign a_q1[1] = in_end_y;
  assign a_q1[2] = in_end_z;
  assign a_q1[3] = in_end_w;
  assign t_in    = (in_fraction > ONE_Q15) ? ONE_Q15 : in_fraction;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [15:0] q0_1_r [4];
  logic signed [15:0] q1_1_r [4];
  logic signed [31:0] pr1_r  [4];
  logic [15:0]        t1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        q0_1_r[i] <= a_q0[i];
        q1_1_r[i] <= a_q1[i];
        pr1_r[i]  <= a_q0[i] * a_q1[i];
      end
      t1_r <= t_in;
    end
  end

  // ---------------- stage 2: dot sum ----------------
  logic signed [15:0] q0_2_r [4];
  logic signed [15:0] q1_2_r [4];
  logic [15:0]        t2_r;
  logic signed [33:0] dot2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q0_2_r <= q0_1_r;
      q1_2_r <= q1_1_r;
      t2_r   <= t1_r;
      dot2_r <= 34'(pr1_r[0]) + 34'(pr1_r[1]) + 34'(pr1_r[2]) + 34'(pr1_r[3]);
    end
  end

  // ---------------- stage 3: shortest path, rounding, path select ----------------
  logic               neg3;
  logic [33:0]        adot3;
  logic [33:0]        dsum3;
  logic [19:0]        dfull3;
  base_t              sb3_nxt, sb3_r;

  assign neg3   = dot2_r[33];
  assign adot3  = neg3 ? 34'(-dot2_r) : 34'(dot2_r);
  assign dsum3  = adot3 + 34'd8192;
  assign dfull3 = dsum3[33:14];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sb3_nxt.q0[i] = neg3 ? 17'(-17'(q0_2_r[i])) : 17'(q0_2_r[i]);
      sb3_nxt.q1[i] = q1_2_r[i];
    end
    sb3_nxt.t   = t2_r;
    sb3_nxt.d   = dfull3[13:0];
    sb3_nxt.lin = (dfull3 >= 20'(thr_r)) || (dfull3 >= ONE_Q14);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb3_r <= sb3_nxt;
    end
  end

  // ---------------- stage 4: radicand (1 - d^2) * 2^60 ----------------
  logic [27:0]     dsq4;
  logic [28:0]     rad4;
  base_t           sb4_r;
  logic [SQ_W-1:0] n4_r;

  assign dsq4 = sb3_r.d * sb3_r.d;
  assign rad4 = 29'h1000_0000 - 29'(dsq4);

  always_ff @(posedge clk) begin
    if (en) begin
      sb4_r <= sb3_r;
      n4_r  <= {rad4, 32'b0};
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  logic              sq_v   [ROOT_W];
  base_t             sq_sb  [ROOT_W];
  logic [ROOT_W-1:0] sq_r   [ROOT_W];
  logic [SQ_W-1:0]   sq_rem [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - j;
    logic              vi;
    base_t             si;
    logic [ROOT_W-1:0] ri;
    logic [SQ_W-1:0]   remi;
    logic [32:0]       trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign vi   = v4_r;
      assign si   = sb4_r;
      assign ri   = '0;
      assign remi = n4_r;
    end else begin : g_next
      assign vi   = sq_v[j-1];
      assign si   = sq_sb[j-1];
      assign ri   = sq_r[j-1];
      assign remi = sq_rem[j-1];
    end

    // r has no bits at or below B yet, so 2r + 2^B is exact
    assign trial = {1'b0, ri, 1'b0} + (33'd1 << B);
    assign ge    = (remi >> B) >= SQ_W'(trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v[j] <= 1'b0;
      end else if (en) begin
        sq_v[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_sb[j] <= si;
        if (ge) begin
          sq_r[j]   <= ri | (ROOT_W'(1) << B);
          sq_rem[j] <= remi - (SQ_W'(trial) << B);
        end else begin
          sq_r[j]   <= ri;
          sq_rem[j] <= remi;
        end
      end
    end
  end

  // ---------------- theta0 = atan2(sin, d) by vectoring ----------------
  mid_t                 vec_in_sb, vec_sb;
  logic                 vec_v;
  logic signed [CW-1:0] vec_x, vec_y, vec_z;

  assign vec_in_sb.b  = sq_sb[ROOT_W-1];
  assign vec_in_sb.s0 = sq_r[ROOT_W-1];

  qslerp_cordic #(
    .ITER      (ITER),
    .VECTORING (1'b1),
    .SB_W      ($bits(mid_t))
  ) u_vec (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_v[ROOT_W-1]),
    .in_sb   (vec_in_sb),
    .in_x    ({4'b0, sq_sb[ROOT_W-1].d, 16'b0}),
    .in_y    ({3'b0, sq_r[ROOT_W-1]}),
    .in_z    ('0),
    .out_vld (vec_v),
    .out_sb  (vec_sb),
    .out_x   (vec_x),
    .out_y   (vec_y),
    .out_z   (vec_z)
  );

  // ---------------- stage 5: theta = theta0 * t ----------------
  logic signed [50:0]   tp5;
  logic                 v5_r;
  mid_t                 sb5_r;
  logic signed [CW-1:0] theta5_r;
  logic signed [50:0]   tsh5;

  assign tp5  = vec_z * $signed({1'b0, vec_sb.b.t});
  assign tsh5 = tp5 >>> 15;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= vec_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb5_r    <= vec_sb;
      theta5_r <= tsh5[CW-1:0];
    end
  end

  // ---------------- sin / cos of theta by rotation ----------------
  mid_t                 rot_sb;
  logic                 rot_v;
  logic signed [CW-1:0] rot_c, rot_s, rot_z;

  qslerp_cordic #(
    .ITER      (ITER),
    .VECTORING (1'b0),
    .SB_W      ($bits(mid_t))
  ) u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v5_r),
    .in_sb   (sb5_r),
    .in_x    (INV_GAIN),
    .in_y    ('0),
    .in_z    (theta5_r),
    .out_vld (rot_v),
    .out_sb  (rot_sb),
    .out_x   (rot_c),
    .out_y   (rot_s),
    .out_z   (rot_z)
  );

  // vectoring x/y and rotation residual angle are not needed downstream
  logic rot_z_unused;
  assign rot_z_unused = ^{rot_z, vec_x, vec_y};

  // ---------------- stage 6: divider setup ----------------
  logic [CW-1:0]     sabs6;
  logic              v6_r;
  div_sb_t           sb6_r;
  logic [ROOT_W-1:0] den6_r;
  logic [DIVR_W-1:0] rem6_r;

  assign sabs6 = rot_s[CW-1] ? CW'(-rot_s) : CW'(rot_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= rot_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb6_r.b   <= rot_sb.b;
      sb6_r.c   <= rot_c;
      sb6_r.neg <= rot_s[CW-1];
      den6_r    <= rot_sb.s0;
      rem6_r    <= {sabs6[31:0], 30'b0};
    end
  end

  // ---------------- s2 = sin(theta) * 2^30 / sin(theta0), restoring ----------------
  logic              dv_v   [QB];
  div_sb_t           dv_sb  [QB];
  logic [ROOT_W-1:0] dv_den [QB];
  logic [DIVR_W-1:0] dv_rem [QB];
  logic [QB-1:0]     dv_q   [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic              vi;
    div_sb_t           si;
    logic [ROOT_W-1:0] deni;
    logic [DIVR_W-1:0] remi;
    logic [QB-1:0]     qi;
    logic              ge;

    if (j == 0) begin : g_first
      assign vi   = v6_r;
      assign si   = sb6_r;
      assign deni = den6_r;
      assign remi = rem6_r;
      assign qi   = '0;
    end else begin : g_next
      assign vi   = dv_v[j-1];
      assign si   = dv_sb[j-1];
      assign deni = dv_den[j-1];
      assign remi = dv_rem[j-1];
      assign qi   = dv_q[j-1];
    end

    assign ge = (remi >> K) >= DIVR_W'(deni);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[j] <= 1'b0;
      end else if (en) begin
        dv_v[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_sb[j]  <= si;
        dv_den[j] <= deni;
        if (ge) begin
          dv_rem[j] <= remi - (DIVR_W'(deni) << K);
          dv_q[j]   <= qi | (QB'(1) << K);
        end else begin
          dv_rem[j] <= remi;
          dv_q[j]   <= qi;
        end
      end
    end
  end

  // ---------------- stages 7..9: s2 sign, d*s2, s1 ----------------
  logic               v7_r, v8_r, v9_r, v10_r;
  div_sb_t            sb7_r, sb8_r;
  base_t              sb9_r, sb10_r;
  logic signed [39:0] s2_7_r, s2_8_r, s2_9_r;
  logic signed [54:0] ds8_r;
  logic signed [54:0] dsh9;
  logic signed [41:0] s1_9_r;
  logic [QB:0]        qz7;

  assign qz7  = {1'b0, dv_q[QB-1]};
  assign dsh9 = ds8_r >>> 14;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (en) begin
      v7_r  <= dv_v[QB-1];
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb7_r  <= dv_sb[QB-1];
      s2_7_r <= dv_sb[QB-1].neg ? -$signed(qz7) : $signed(qz7);
      sb8_r  <= sb7_r;
      s2_8_r <= s2_7_r;
      ds8_r  <= $signed({1'b0, sb7_r.b.d}) * s2_7_r;
      sb9_r  <= sb8_r.b;
      s2_9_r <= s2_8_r;
      s1_9_r <= 42'(sb8_r.c) - dsh9[41:0];
    end
  end

  // ---------------- stage 10: weight products ----------------
  logic signed [58:0] ps1_r [4];
  logic signed [55:0] ps2_r [4];
  logic signed [33:0] pl0_r [4];
  logic signed [32:0] pl1_r [4];
  logic [16:0]        tc9;

  assign tc9 = 17'(ONE_Q15) - 17'(sb9_r.t);

  always_ff @(posedge clk) begin
    if (en) begin
      sb10_r <= sb9_r;
      for (int i = 0; i < 4; i++) begin
        ps1_r[i] <= s1_9_r * $signed(sb9_r.q0[i]);
        ps2_r[i] <= s2_9_r * $signed(sb9_r.q1[i]);
        pl0_r[i] <= $signed(tc9) * $signed(sb9_r.q0[i]);
        pl1_r[i] <= $signed({1'b0, sb9_r.t}) * $signed(sb9_r.q1[i]);
      end
    end
  end

  // ---------------- stage 11: round, saturate, output register ----------------
  logic signed [59:0] acc11 [4];
  logic signed [59:0] sh11  [4];
  logic signed [34:0] lac11 [4];
  logic signed [34:0] lsh11 [4];
  logic [15:0]        res11 [4];
  logic [15:0]        o_r   [4];
  logic               lin_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc11[i] = 60'(ps1_r[i]) + 60'(ps2_r[i]) + 60'sh2000_0000;
      sh11[i]  = acc11[i] >>> 30;
      lac11[i] = 35'(pl0_r[i]) + 35'(pl1_r[i]) + 35'sd16384;
      lsh11[i] = lac11[i] >>> 15;
      res11[i] = sb10_r.lin ? sat16(64'(lsh11[i])) : sat16(64'(sh11[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r   <= res11;
      lin_r <= sb10_r.lin;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = o_r[0];
  assign out_y           = o_r[1];
  assign out_z           = o_r[2];
  assign out_w           = o_r[3];
  assign out_used_linear = lin_r;

  // ---------------- assertions ----------------
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(v3_r) && $stable(sq_v[ROOT_W-1])
                                    && $stable(dv_v[QB-1])))
    else $error("pipeline moved while output beat was stalled");

  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_v[ROOT_W-1] && !sq_sb[ROOT_W-1].lin) |-> (sq_r[ROOT_W-1] >= S0_MIN))
    else $error("sin(theta0) below its lower bound");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v[QB-1] && !dv_sb[QB-1].b.lin) |->
      (dv_rem[QB-1] < DIVR_W'(dv_den[QB-1])))
    else $error("divider remainder not below divisor");

endmodule

[rtl/qslerp_cordic.sv]
// ----------------------------------------------------------------------------
// qslerp_cordic
// Unrolled CORDIC, one micro-rotation per register stage. Vectoring mode
// drives y toward zero; rotation mode drives z toward zero.
// ----------------------------------------------------------------------------
module qslerp_cordic #(
  parameter int ITER      = qslerp_pkg::TRIG_ITER_DEF,
  parameter bit VECTORING = 1'b0,
  parameter int SB_W      = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [SB_W-1:0]                   in_sb,
  input  logic signed [qslerp_pkg::CW-1:0]  in_x,
  input  logic signed [qslerp_pkg::CW-1:0]  in_y,
  input  logic signed [qslerp_pkg::CW-1:0]  in_z,
  output logic                              out_vld,
  output logic [SB_W-1:0]                   out_sb,
  output logic signed [qslerp_pkg::CW-1:0]  out_x,
  output logic signed [qslerp_pkg::CW-1:0]  out_y,
  output logic signed [qslerp_pkg::CW-1:0]  out_z
);
  import qslerp_pkg::*;

  logic                 v_r  [ITER];
  logic [SB_W-1:0]      sb_r [ITER];
  logic signed [CW-1:0] x_r  [ITER];
  logic signed [CW-1:0] y_r  [ITER];
  logic signed [CW-1:0] z_r  [ITER];

  for (genvar n = 0; n < ITER; n++) begin : g_stage
    logic                 vi;
    logic [SB_W-1:0]      si;
    logic signed [CW-1:0] xi, yi, zi, xs, ys;
    logic                 ccw;

    if (n == 0) begin : g_first
      assign vi = in_vld;
      assign si = in_sb;
      assign xi = in_x;
      assign yi = in_y;
      assign zi = in_z;
    end else begin : g_next
      assign vi = v_r[n-1];
      assign si = sb_r[n-1];
      assign xi = x_r[n-1];
      assign yi = y_r[n-1];
      assign zi = z_r[n-1];
    end

    assign xs  = xi >>> n;
    assign ys  = yi >>> n;
    assign ccw = VECTORING ? !(yi > 0) : (zi >= 0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[n] <= 1'b0;
      end else if (en) begin
        v_r[n] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[n] <= si;
        if (ccw) begin
          x_r[n] <= xi - ys;
          y_r[n] <= yi + xs;
          z_r[n] <= zi - ATAN_TAB[n];
        end else begin
          x_r[n] <= xi + ys;
          y_r[n] <= yi - xs;
          z_r[n] <= zi + ATAN_TAB[n];
        end
      end
    end
  end

  assign out_vld = v_r[ITER-1];
  assign out_sb  = sb_r[ITER-1];
  assign out_x   = x_r[ITER-1];
  assign out_y   = y_r[ITER-1];
  assign out_z   = z_r[ITER-1];

endmodule
